// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared widths, codes, state and command types for the allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Default sizes of the allocator.
    localparam int MAX_ORDER_DEF      = 11;
    localparam int POOL_PAGES_MAX_DEF = 4096;

    // Fixed field widths.
    localparam int ORDER_W  = 4;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int BASE_W   = 36;
    localparam int STATUS_W = 2;

    // Reset value of the pool size register.
    localparam logic [COUNT_W-1:0] POOL_PAGES_RESET = 13'd4096;

    // Request codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_POOL_BASE  = 1'b0;
    localparam logic CFG_POOL_PAGES = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ORDER_BIG = 2'd1,
        ST_NO_FREE   = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_A_SRCH,
        S_A_TAKE,
        S_A_RM_RD,
        S_A_RM_WR,
        S_A_SCHK,
        S_A_SDEC,
        S_A_PUSH1,
        S_A_PUSH2,
        S_A_FIN,
        S_F_RD,
        S_F_CHK,
        S_M_CHK,
        S_M_BRD,
        S_M_BTST,
        S_M_RM_WR,
        S_M_UPD1,
        S_M_UPD2,
        S_M_PUSH1,
        S_M_PUSH2,
        S_OUT_OK,
        S_OUT_BIG,
        S_OUT_NONE
    } t_state;

    // Datapath operations, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_SRCH,
        OP_TAKE,
        OP_RD_IDX,
        OP_RD_BUD,
        OP_RM_WR,
        OP_BUD,
        OP_BUD_DN,
        OP_KDEC,
        OP_PUSH1,
        OP_PUSH2,
        OP_PUSH2_ADV,
        OP_FIN,
        OP_FRD,
        OP_FCLR,
        OP_BRD,
        OP_KINC_O1,
        OP_O2,
        OP_OUT
    } t_dp_op;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic order_big;
        logic k_at_max;
        logic list_ok;
        logic k_gt_order;
        logic bud_ok;
        logic pidx_ok;
        logic rd_alloc;
        logic rd_order_eq;
        logic k_lt_top;
        logic clr_done;
        logic out_full;
    } t_dp_stat;

endpackage

// ===== rtl/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// Allocator metadata RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int DEPTH = bpa_pkg::POOL_PAGES_MAX_DEF,
    parameter int WIDTH = bpa_pkg::COUNT_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpa_datapath.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Page metadata memories, free list heads and counts, buddy arithmetic,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module bpa_datapath #(
    parameter int MAX_ORDER      = bpa_pkg::MAX_ORDER_DEF,
    parameter int POOL_PAGES_MAX = bpa_pkg::POOL_PAGES_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_dp_cmd              i_ctl,
    output bpa_pkg::t_dp_stat             o_sts,
    input  logic                          i_in_cmd,
    input  logic [bpa_pkg::ORDER_W-1:0]   i_in_order,
    input  logic [bpa_pkg::INDEX_W-1:0]   i_in_page_index,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [bpa_pkg::BASE_W-1:0]    i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [bpa_pkg::STATUS_W-1:0]  o_status,
    output logic [bpa_pkg::INDEX_W-1:0]   o_alloc_index,
    output logic [bpa_pkg::COUNT_W-1:0]   o_free_pages
);

    import bpa_pkg::*;

    localparam int IW = $clog2(POOL_PAGES_MAX);
    localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam logic [COUNT_W-1:0] NULL_LINK = COUNT_W'(POOL_PAGES_MAX);
    localparam logic [ORDER_W-1:0] K_MAX     = ORDER_W'(MAX_ORDER);
    localparam logic [ORDER_W-1:0] K_TOP     = ORDER_W'(MAX_ORDER - 1);
    localparam logic [IW-1:0]      CLR_LAST  = IW'(POOL_PAGES_MAX - 1);

    // Buddy of chunk idx at order kk, pool relative, with an in-pool flag on top.
    // Only the low bits of the base decide whether bit kk of the absolute
    // page number is set, so the buddy lies one span above or below.
    function automatic logic [IW:0] buddy_of(
        input logic [IW-1:0]      idx,
        input logic [ORDER_W-1:0] kk,
        input logic [COUNT_W-1:0] base_lo,
        input logic [COUNT_W-1:0] size
    );
        logic [COUNT_W:0]   sum;
        logic [COUNT_W:0]   sum_sh;
        logic [COUNT_W+1:0] span;
        logic [COUNT_W+1:0] rel;
        logic               ok;
        sum    = {1'b0, base_lo} + (COUNT_W + 1)'(idx);
        sum_sh = sum >> kk;
        span   = (COUNT_W + 2)'(1) << kk;
        rel    = sum_sh[0] ? ((COUNT_W + 2)'(idx) - span) : ((COUNT_W + 2)'(idx) + span);
        ok     = !rel[COUNT_W+1] && ((rel + span) <= {2'b00, size});
        return {ok, rel[IW-1:0]};
    endfunction

    // Configuration and control registers.
    logic [COUNT_W-1:0] r_base_lo;
    logic [COUNT_W-1:0] r_pages;
    logic [COUNT_W-1:0] r_head [MAX_ORDER];
    logic [COUNT_W-1:0] r_count [MAX_ORDER];
    logic [COUNT_W-1:0] r_free;
    logic               r_ovalid;
    logic [IW-1:0]      r_clr;

    // Working registers of the current request.
    logic               r_cmd;
    logic [ORDER_W-1:0] r_order;
    logic [INDEX_W-1:0] r_pidx;
    logic [ORDER_W-1:0] r_k;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_bud;
    logic               r_bok;
    logic [COUNT_W-1:0] r_h;
    t_status            r_ostatus;
    logic [INDEX_W-1:0] r_oindex;
    logic [COUNT_W-1:0] r_ofree;

    // Combinational values.
    logic [COUNT_W-1:0] w_size;
    logic [COUNT_W-1:0] w_span;
    logic [KW-1:0]      w_kx;
    logic [COUNT_W-1:0] w_head_k;
    logic [COUNT_W-1:0] w_count_k;
    logic [ORDER_W-1:0] w_bud_k;
    logic [IW:0]        w_bud_res;

    // Memory ports.
    logic               w_ord_we;
    logic [IW-1:0]      w_ord_waddr;
    logic [ORDER_W-1:0] w_ord_wdata;
    logic [ORDER_W-1:0] w_ord_rd;
    logic               w_alc_we;
    logic [IW-1:0]      w_alc_waddr;
    logic               w_alc_wdata;
    logic               w_alc_rd;
    logic               w_nxt_we;
    logic [IW-1:0]      w_nxt_waddr;
    logic [COUNT_W-1:0] w_nxt_wdata;
    logic [COUNT_W-1:0] w_nxt_rd;
    logic               w_prv_we;
    logic [IW-1:0]      w_prv_waddr;
    logic [COUNT_W-1:0] w_prv_wdata;
    logic [COUNT_W-1:0] w_prv_rd;
    logic [IW-1:0]      w_raddr;

    assign w_size    = (r_pages < COUNT_W'(POOL_PAGES_MAX)) ? r_pages : COUNT_W'(POOL_PAGES_MAX);
    assign w_span    = COUNT_W'(1) << r_k;
    assign w_kx      = r_k[KW-1:0];
    assign w_head_k  = r_head[w_kx];
    assign w_count_k = r_count[w_kx];
    assign w_bud_k   = (i_ctl.op == OP_BUD_DN) ? (r_k - ORDER_W'(1)) : r_k;
    assign w_bud_res = buddy_of(r_idx, w_bud_k, r_base_lo, w_size);

    // Page order, allocated bit and list link memories.
    bpa_ram #(.DEPTH(POOL_PAGES_MAX), .WIDTH(ORDER_W)) u_order_ram (
        .i_clk  (i_clk),
        .i_we   (w_ord_we),
        .i_waddr(w_ord_waddr),
        .i_wdata(w_ord_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_ord_rd)
    );

    bpa_ram #(.DEPTH(POOL_PAGES_MAX), .WIDTH(1)) u_alloc_ram (
        .i_clk  (i_clk),
        .i_we   (w_alc_we),
        .i_waddr(w_alc_waddr),
        .i_wdata(w_alc_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_alc_rd)
    );

    bpa_ram #(.DEPTH(POOL_PAGES_MAX), .WIDTH(COUNT_W)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (w_nxt_we),
        .i_waddr(w_nxt_waddr),
        .i_wdata(w_nxt_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_nxt_rd)
    );

    bpa_ram #(.DEPTH(POOL_PAGES_MAX), .WIDTH(COUNT_W)) u_prev_ram (
        .i_clk  (i_clk),
        .i_we   (w_prv_we),
        .i_waddr(w_prv_waddr),
        .i_wdata(w_prv_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_prv_rd)
    );

    // Memory address and write data selection per operation.
    always_comb begin
        w_ord_we    = 1'b0;
        w_ord_waddr = r_idx;
        w_ord_wdata = r_k;
        w_alc_we    = 1'b0;
        w_alc_waddr = r_idx;
        w_alc_wdata = 1'b0;
        w_nxt_we    = 1'b0;
        w_nxt_waddr = r_idx;
        w_nxt_wdata = w_head_k;
        w_prv_we    = 1'b0;
        w_prv_waddr = r_idx;
        w_prv_wdata = NULL_LINK;
        w_raddr     = r_idx;
        case (i_ctl.op)
            OP_CLR: begin
                w_ord_we    = 1'b1;
                w_ord_waddr = r_clr;
                w_ord_wdata = '0;
                w_alc_we    = 1'b1;
                w_alc_waddr = r_clr;
                w_alc_wdata = 1'b1;
            end
            OP_FRD: begin
                w_raddr = r_pidx[IW-1:0];
            end
            OP_BRD, OP_RD_BUD: begin
                w_raddr = r_bud;
            end
            OP_RD_IDX: begin
                w_raddr = r_idx;
            end
            OP_RM_WR: begin
                // Unlink: predecessor skips over, successor points back.
                if (w_prv_rd < NULL_LINK) begin
                    w_nxt_we    = 1'b1;
                    w_nxt_waddr = w_prv_rd[IW-1:0];
                    w_nxt_wdata = w_nxt_rd;
                end
                if (w_nxt_rd < NULL_LINK) begin
                    w_prv_we    = 1'b1;
                    w_prv_waddr = w_nxt_rd[IW-1:0];
                    w_prv_wdata = w_prv_rd;
                end
            end
            OP_PUSH1: begin
                w_ord_we = 1'b1;
                w_nxt_we = 1'b1;
                w_prv_we = 1'b1;
            end
            OP_PUSH2, OP_PUSH2_ADV: begin
                if (r_h < NULL_LINK) begin
                    w_prv_we    = 1'b1;
                    w_prv_waddr = r_h[IW-1:0];
                    w_prv_wdata = COUNT_W'(r_idx);
                end
            end
            OP_FIN: begin
                w_ord_we    = 1'b1;
                w_alc_we    = 1'b1;
                w_alc_wdata = 1'b1;
            end
            OP_FCLR: begin
                w_alc_we = 1'b1;
            end
            OP_KINC_O1: begin
                w_ord_we    = 1'b1;
                w_ord_wdata = r_k + ORDER_W'(1);
            end
            OP_O2: begin
                w_ord_we    = 1'b1;
                w_ord_waddr = r_bud;
            end
            default: begin
            end
        endcase
    end

    // Configuration, list heads and counts, free total, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_ORDER; j++) begin
                r_head[j]  <= NULL_LINK;
                r_count[j] <= '0;
            end
            r_free    <= '0;
            r_ovalid  <= 1'b0;
            r_clr     <= '0;
            r_base_lo <= '0;
            r_pages   <= POOL_PAGES_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_POOL_BASE) begin
                    r_base_lo <= i_cfg_data[COUNT_W-1:0];
                end else begin
                    r_pages <= i_cfg_data[COUNT_W-1:0];
                end
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (i_ctl.op)
                OP_CLR: begin
                    r_clr <= r_clr + IW'(1);
                end
                OP_RM_WR: begin
                    if (!(w_prv_rd < NULL_LINK)) begin
                        r_head[w_kx] <= w_nxt_rd;
                    end
                    r_count[w_kx] <= r_count[w_kx] - COUNT_W'(1);
                    r_free        <= r_free - w_span;
                end
                OP_PUSH1: begin
                    r_head[w_kx]  <= COUNT_W'(r_idx);
                    r_count[w_kx] <= r_count[w_kx] + COUNT_W'(1);
                    r_free        <= r_free + w_span;
                end
                OP_FIN, OP_OUT: begin
                    r_ovalid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the request and the result payload.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LOAD: begin
                r_cmd   <= i_in_cmd;
                r_order <= i_in_order;
                r_pidx  <= i_in_page_index;
                r_k     <= i_in_order;
            end
            OP_SRCH: begin
                r_k <= r_k + ORDER_W'(1);
            end
            OP_TAKE: begin
                r_idx <= w_head_k[IW-1:0];
            end
            OP_BUD, OP_BUD_DN: begin
                r_bok <= w_bud_res[IW];
                r_bud <= w_bud_res[IW-1:0];
            end
            OP_KDEC: begin
                r_k <= r_k - ORDER_W'(1);
            end
            OP_PUSH1: begin
                r_h <= w_head_k;
            end
            OP_PUSH2_ADV: begin
                r_idx <= r_bud;
            end
            OP_FRD: begin
                r_idx <= r_pidx[IW-1:0];
            end
            OP_FCLR: begin
                r_k <= (w_ord_rd >= K_TOP) ? K_TOP : w_ord_rd;
            end
            OP_KINC_O1: begin
                r_k <= r_k + ORDER_W'(1);
            end
            OP_O2: begin
                if (r_bud < r_idx) begin
                    r_idx <= r_bud;
                end
            end
            OP_FIN: begin
                r_ostatus <= ST_OK;
                r_oindex  <= INDEX_W'(r_idx);
                r_ofree   <= r_free;
            end
            OP_OUT: begin
                r_ostatus <= i_ctl.status;
                r_oindex  <= '0;
                r_ofree   <= r_free;
            end
            default: begin
            end
        endcase
    end

    // Status towards the controller.
    assign o_sts.is_free     = (r_cmd == CMD_FREE);
    assign o_sts.order_big   = (r_order >= K_MAX);
    assign o_sts.k_at_max    = (r_k >= K_MAX);
    assign o_sts.list_ok     = (w_count_k != '0) && (w_head_k < NULL_LINK);
    assign o_sts.k_gt_order  = (r_k > r_order);
    assign o_sts.bud_ok      = r_bok;
    assign o_sts.pidx_ok     = ({1'b0, r_pidx} < w_size);
    assign o_sts.rd_alloc    = w_alc_rd;
    assign o_sts.rd_order_eq = (w_ord_rd == r_k);
    assign o_sts.k_lt_top    = (r_k < K_TOP);
    assign o_sts.clr_done    = (r_clr == CLR_LAST);
    assign o_sts.out_full    = r_ovalid;

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_alloc_index = r_oindex;
    assign o_free_pages  = r_ofree;

endmodule

// ===== rtl/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences the clearing pass, order search, splitting and merging by
// issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bpa_pkg::t_dp_stat i_sts,
    output bpa_pkg::t_dp_cmd  o_ctl
);

    import bpa_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.is_free) n_state = S_F_RD;
                else if (i_sts.order_big) n_state = S_OUT_BIG;
                else n_state = S_A_SRCH;
            end
            S_A_SRCH: begin
                if (i_sts.k_at_max) n_state = S_OUT_NONE;
                else if (i_sts.list_ok) n_state = S_A_TAKE;
            end
            S_A_TAKE:  n_state = S_A_RM_RD;
            S_A_RM_RD: n_state = S_A_RM_WR;
            S_A_RM_WR: n_state = S_A_SCHK;
            S_A_SCHK: begin
                if (i_sts.k_gt_order) n_state = S_A_SDEC;
                else n_state = S_A_FIN;
            end
            S_A_SDEC: begin
                if (i_sts.bud_ok) n_state = S_A_PUSH1;
                else n_state = S_A_FIN;
            end
            S_A_PUSH1: n_state = S_A_PUSH2;
            S_A_PUSH2: n_state = S_A_SCHK;
            S_A_FIN: begin
                if (!i_sts.out_full) n_state = S_IDLE;
            end
            S_F_RD: begin
                if (i_sts.pidx_ok) n_state = S_F_CHK;
                else n_state = S_OUT_OK;
            end
            S_F_CHK: begin
                if (i_sts.rd_alloc) n_state = S_M_CHK;
                else n_state = S_OUT_OK;
            end
            S_M_CHK: begin
                if (i_sts.k_lt_top) n_state = S_M_BRD;
                else n_state = S_M_PUSH1;
            end
            S_M_BRD: begin
                if (i_sts.bud_ok) n_state = S_M_BTST;
                else n_state = S_M_PUSH1;
            end
            S_M_BTST: begin
                if (i_sts.rd_alloc || !i_sts.rd_order_eq) n_state = S_M_PUSH1;
                else n_state = S_M_RM_WR;
            end
            S_M_RM_WR: n_state = S_M_UPD1;
            S_M_UPD1:  n_state = S_M_UPD2;
            S_M_UPD2:  n_state = S_M_CHK;
            S_M_PUSH1: n_state = S_M_PUSH2;
            S_M_PUSH2: n_state = S_OUT_OK;
            S_OUT_OK, S_OUT_BIG, S_OUT_NONE: begin
                if (!i_sts.out_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath operation and input stall.
    always_comb begin
        o_ctl.op     = OP_NONE;
        o_ctl.status = ST_OK;
        o_in_stall   = 1'b1;
        case (r_state)
            S_CLEAR: o_ctl.op = OP_CLR;
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_ctl.op = OP_LOAD;
            end
            S_A_SRCH: begin
                if (!i_sts.k_at_max && !i_sts.list_ok) o_ctl.op = OP_SRCH;
            end
            S_A_TAKE:  o_ctl.op = OP_TAKE;
            S_A_RM_RD: o_ctl.op = OP_RD_IDX;
            S_A_RM_WR: o_ctl.op = OP_RM_WR;
            S_A_SCHK: begin
                if (i_sts.k_gt_order) o_ctl.op = OP_BUD_DN;
            end
            S_A_SDEC: begin
                if (i_sts.bud_ok) o_ctl.op = OP_KDEC;
            end
            S_A_PUSH1: o_ctl.op = OP_PUSH1;
            S_A_PUSH2: o_ctl.op = OP_PUSH2_ADV;
            S_A_FIN: begin
                if (!i_sts.out_full) o_ctl.op = OP_FIN;
            end
            S_F_RD: begin
                if (i_sts.pidx_ok) o_ctl.op = OP_FRD;
            end
            S_F_CHK: begin
                if (i_sts.rd_alloc) o_ctl.op = OP_FCLR;
            end
            S_M_CHK: begin
                if (i_sts.k_lt_top) o_ctl.op = OP_BUD;
            end
            S_M_BRD: begin
                if (i_sts.bud_ok) o_ctl.op = OP_BRD;
            end
            S_M_BTST: begin
                if (!i_sts.rd_alloc && i_sts.rd_order_eq) o_ctl.op = OP_RD_BUD;
            end
            S_M_RM_WR: o_ctl.op = OP_RM_WR;
            S_M_UPD1:  o_ctl.op = OP_KINC_O1;
            S_M_UPD2:  o_ctl.op = OP_O2;
            S_M_PUSH1: o_ctl.op = OP_PUSH1;
            S_M_PUSH2: o_ctl.op = OP_PUSH2;
            S_OUT_OK: begin
                if (!i_sts.out_full) o_ctl.op = OP_OUT;
            end
            S_OUT_BIG: begin
                o_ctl.status = ST_ORDER_BIG;
                if (!i_sts.out_full) o_ctl.op = OP_OUT;
            end
            S_OUT_NONE: begin
                o_ctl.status = ST_NO_FREE;
                if (!i_sts.out_full) o_ctl.op = OP_OUT;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// Allocate: searches the free lists upward from the order, then splits down level by level.
// Free: merges level by level; the next request can be taken as soon as the result is presented.
// Each level read-modify-writes the page metadata RAMs, one read and one write port each.
// A new request is taken while the previous result waits in the output register.
// Reset (synchronous, active low) starts a clearing pass over all POOL_PAGES_MAX pages
// that marks every page allocated at order 0; requests are stalled until it ends.
// ----------------------------------------------------------------------------
// Buddy page allocator
// Top level: controller and datapath, request and result channels and the
// configuration write port.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
    parameter int MAX_ORDER      = bpa_pkg::MAX_ORDER_DEF,
    parameter int POOL_PAGES_MAX = bpa_pkg::POOL_PAGES_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [bpa_pkg::ORDER_W-1:0]   i_order,
    input  logic [bpa_pkg::INDEX_W-1:0]   i_page_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bpa_pkg::STATUS_W-1:0]  o_status,
    output logic [bpa_pkg::INDEX_W-1:0]   o_alloc_index,
    output logic [bpa_pkg::COUNT_W-1:0]   o_free_pages,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [bpa_pkg::BASE_W-1:0]    i_cfg_data
);

    import bpa_pkg::*;

    t_dp_cmd  w_ctl;
    t_dp_stat w_sts;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_valid),
        .o_in_stall(o_stall),
        .i_sts     (w_sts),
        .o_ctl     (w_ctl)
    );

    bpa_datapath #(
        .MAX_ORDER     (MAX_ORDER),
        .POOL_PAGES_MAX(POOL_PAGES_MAX)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_in_cmd       (i_cmd),
        .i_in_order     (i_order),
        .i_in_page_index(i_page_index),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_status       (o_status),
        .o_alloc_index  (o_alloc_index),
        .o_free_pages   (o_free_pages)
    );

    // Only one request is in the sequencer at a time.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken while another is in progress");

    // A failed allocation reports page index zero.
    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_alloc_index == '0))
        else $error("failure result with non-zero page index");

    // Only defined status codes are reported.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_ORDER_BIG ||
                     o_status == ST_NO_FREE))
        else $error("undefined status code");

endmodule

// ===== tb/buddy_page_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free requests through the request channel. Each result is
// checked against a fixed row of the short directed table, which comes first, or
// else a cycle-free predictor of the free lists. Phased random traffic follows under
// several pool settings with varied sender gaps, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int NUM_ORDERS = MAX_ORDER_DEF;
    localparam int PAGES_CAP  = POOL_PAGES_MAX_DEF;
    localparam logic [COUNT_W-1:0] NO_LINK = 13'(POOL_PAGES_MAX_DEF);
    localparam int unsigned NO_BUDDY_IDX = 32'hFFFF_FFFF;

    typedef struct {
        t_status              status;
        logic [INDEX_W-1:0]   index;
        logic [COUNT_W-1:0]   free_pages;
    } alloc_result_t;

    typedef struct {
        logic                 cmd;
        logic [ORDER_W-1:0]   order;
        logic [INDEX_W-1:0]   page;
        bit                   fixed;
        t_status              status;
        logic [INDEX_W-1:0]   index;
        logic [COUNT_W-1:0]   free_pages;
    } directed_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_cmd = CMD_ALLOC;
    logic [ORDER_W-1:0]   i_order = '0;
    logic [INDEX_W-1:0]   i_page_index = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [INDEX_W-1:0]   o_alloc_index;
    logic [COUNT_W-1:0]   o_free_pages;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = CFG_POOL_BASE;
    logic [BASE_W-1:0]    i_cfg_data = '0;

    buddy_page_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_order       (i_order),
        .i_page_index  (i_page_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_alloc_index (o_alloc_index),
        .o_free_pages  (o_free_pages),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock and reset.
    always #10 i_clk = ~i_clk;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Overall time limit.
    initial begin
        #60_000_000;
        $display("buddy_page_allocator_tb: done, errors");
        $finish;
    end

    // Shadow copy of the allocator state.
    logic [BASE_W-1:0]    pool_base = '0;
    logic [COUNT_W-1:0]   pool_count = POOL_PAGES_RESET;
    logic [ORDER_W-1:0]   chunk_order [PAGES_CAP];
    bit                   in_use [PAGES_CAP];
    logic [COUNT_W-1:0]   next_link [PAGES_CAP];
    logic [COUNT_W-1:0]   prev_link [PAGES_CAP];
    logic [COUNT_W-1:0]   free_head [NUM_ORDERS];
    logic [COUNT_W-1:0]   free_count [NUM_ORDERS];
    logic [COUNT_W-1:0]   pages_free = '0;

    alloc_result_t        pending_results[$];
    int unsigned          live_heads[$];
    int unsigned          error_count = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          stall_pct = 0;
    logic                 hold_rx = 1'b0;

    initial begin
        for (int i = 0; i < PAGES_CAP; i++) begin
            chunk_order[i] = '0;
            in_use[i] = 1'b1;
            next_link[i] = '0;
            prev_link[i] = '0;
        end
        for (int k = 0; k < NUM_ORDERS; k++) begin
            free_head[k] = NO_LINK;
            free_count[k] = '0;
        end
    end

    function automatic int unsigned pool_limit();
        return (pool_count < PAGES_CAP) ? int'(pool_count) : PAGES_CAP;
    endfunction

    // Buddy of a chunk by XOR of the absolute page number; must lie in the pool.
    function automatic int unsigned buddy_index(int unsigned idx, int unsigned k);
        longint unsigned span;
        longint unsigned abs_page;
        longint unsigned bud;
        span = 64'd1 << k;
        abs_page = 64'(pool_base) + idx;
        bud = abs_page ^ span;
        if (bud < 64'(pool_base) || bud + span > 64'(pool_base) + pool_limit())
            return NO_BUDDY_IDX;
        return int'(bud - 64'(pool_base));
    endfunction

    function automatic void list_insert(int unsigned idx, int unsigned k);
        logic [COUNT_W-1:0] h;
        h = free_head[k];
        prev_link[idx] = NO_LINK;
        next_link[idx] = h;
        if (h < NO_LINK)
            prev_link[h] = 13'(idx);
        free_head[k] = 13'(idx);
        free_count[k] = free_count[k] + 13'd1;
        pages_free = pages_free + 13'(1 << k);
    endfunction

    function automatic void list_unlink(int unsigned idx, int unsigned k);
        logic [COUNT_W-1:0] p;
        logic [COUNT_W-1:0] n;
        p = prev_link[idx];
        n = next_link[idx];
        if (p < NO_LINK)
            next_link[p] = n;
        else
            free_head[k] = n;
        if (n < NO_LINK)
            prev_link[n] = p;
        free_count[k] = free_count[k] - 13'd1;
        pages_free = pages_free - 13'(1 << k);
    endfunction

    // Applies one request to the shadow state and returns its result.
    function automatic alloc_result_t apply_request(logic cmd, logic [ORDER_W-1:0] order,
                                                    logic [INDEX_W-1:0] page);
        alloc_result_t res;
        int unsigned   k;
        int unsigned   head;
        int unsigned   up;
        int unsigned   idx;
        int unsigned   bud;
        res.status = ST_OK;
        res.index = '0;
        if (cmd == CMD_ALLOC) begin
            if (order >= NUM_ORDERS) begin
                res.status = ST_ORDER_BIG;
            end else begin
                k = order;
                while (k < NUM_ORDERS && !(free_count[k] != 0 && free_head[k] < NO_LINK))
                    k++;
                if (k >= NUM_ORDERS) begin
                    res.status = ST_NO_FREE;
                end else begin
                    head = free_head[k];
                    list_unlink(head, k);
                    // Split down, keeping the lower half free and going on with the upper.
                    while (k > order) begin
                        up = buddy_index(head, k - 1);
                        if (up == NO_BUDDY_IDX)
                            break;
                        k--;
                        chunk_order[head] = 4'(k);
                        list_insert(head, k);
                        head = up;
                    end
                    chunk_order[head] = 4'(k);
                    in_use[head] = 1'b1;
                    res.index = 12'(head);
                    live_heads.push_back(head);
                end
            end
        end else if (page < pool_limit() && in_use[page]) begin
            idx = page;
            k = chunk_order[idx];
            if (k >= NUM_ORDERS)
                k = NUM_ORDERS - 1;
            in_use[idx] = 1'b0;
            // Merge with free buddies of equal order.
            while (k < NUM_ORDERS - 1) begin
                bud = buddy_index(idx, k);
                if (bud == NO_BUDDY_IDX || in_use[bud] || chunk_order[bud] != k)
                    break;
                list_unlink(bud, k);
                k++;
                chunk_order[idx] = 4'(k);
                chunk_order[bud] = 4'(k);
                if (bud < idx)
                    idx = bud;
            end
            chunk_order[idx] = 4'(k);
            list_insert(idx, k);
        end
        res.free_pages = pages_free;
        return res;
    endfunction

    // Result side: check accepted results and drive the stall.
    always @(posedge i_clk) begin
        alloc_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_alloc_index !== want.index) begin
                    $error("alloc_index expected %0d got %0d", want.index, o_alloc_index);
                    error_count++;
                end
                if (o_free_pages !== want.free_pages) begin
                    $error("free_pages expected %0d got %0d", want.free_pages, o_free_pages);
                    error_count++;
                end
            end
        end
        i_stall <= hold_rx || ($urandom_range(99) < stall_pct);
    end

    // Offers one request, waits for it to be taken and records its result.
    task automatic send_request(logic cmd, logic [ORDER_W-1:0] order, logic [INDEX_W-1:0] page,
                                bit fixed, alloc_result_t fixed_res);
        alloc_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_order <= order;
        i_page_index <= page;
        do @(posedge i_clk); while (o_stall);
        res = apply_request(cmd, order, page);
        pending_results.push_back(fixed ? fixed_res : res);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [BASE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_POOL_BASE)
            pool_base = data;
        else
            pool_count = data[COUNT_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One phase: new pool settings, optional freeing of every pool page, then traffic.
    task automatic run_phase(logic [BASE_W-1:0] base, logic [BASE_W-1:0] pages,
                             int unsigned s_pct, int unsigned r_pct, int unsigned n_items,
                             bit free_all, bit hold_off);
        int unsigned   order_list[$];
        int unsigned   j;
        int unsigned   tmp;
        int unsigned   roll;
        alloc_result_t none;
        none = '{ST_OK, '0, '0};
        wait_idle();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_POOL_PAGES, pages);
        send_idle_pct = s_pct;
        stall_pct = r_pct;
        if (hold_off) begin
            fork
                begin
                    hold_rx <= 1'b1;
                    repeat (400) @(posedge i_clk);
                    hold_rx <= 1'b0;
                end
            join_none
        end
        if (free_all) begin
            for (int i = 0; i < pool_limit(); i++)
                order_list.push_back(i);
            for (int i = order_list.size() - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = order_list[i];
                order_list[i] = order_list[j];
                order_list[j] = tmp;
            end
            foreach (order_list[i])
                send_request(CMD_FREE, 4'($urandom), 12'(order_list[i]), 1'b0, none);
        end
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                send_request(CMD_ALLOC,
                             ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                      : 4'($urandom_range(3)),
                             12'($urandom), 1'b0, none);
            end else if (roll < 90 && live_heads.size() != 0) begin
                j = $urandom_range(live_heads.size() - 1);
                tmp = live_heads[j];
                live_heads.delete(j);
                send_request(CMD_FREE, 4'($urandom), 12'(tmp), 1'b0, none);
            end else begin
                send_request(CMD_FREE, 4'($urandom), 12'($urandom_range(4095)), 1'b0, none);
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    directed_row_t directed_rows[] = '{
        '{CMD_ALLOC, 4'd0,  12'd0,    1'b1, ST_NO_FREE,   12'd0,    13'd0},
        '{CMD_ALLOC, 4'd15, 12'd4095, 1'b1, ST_ORDER_BIG, 12'd0,    13'd0},
        '{CMD_ALLOC, 4'd11, 12'd0,    1'b1, ST_ORDER_BIG, 12'd0,    13'd0},
        '{CMD_FREE,  4'd0,  12'd4095, 1'b1, ST_OK,        12'd0,    13'd1},
        '{CMD_FREE,  4'd15, 12'd4095, 1'b1, ST_OK,        12'd0,    13'd1},
        '{CMD_FREE,  4'd0,  12'd4094, 1'b1, ST_OK,        12'd0,    13'd2},
        '{CMD_ALLOC, 4'd0,  12'd0,    1'b1, ST_OK,        12'd4095, 13'd1},
        '{CMD_FREE,  4'd0,  12'd0,    1'b1, ST_OK,        12'd0,    13'd2},
        '{CMD_ALLOC, 4'd10, 12'd0,    1'b1, ST_NO_FREE,   12'd0,    13'd2},
        '{CMD_FREE,  4'd0,  12'd4095, 1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_FREE,  4'd0,  12'd1,    1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_FREE,  4'd0,  12'd2,    1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_FREE,  4'd0,  12'd3,    1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_FREE,  4'd0,  12'd1,    1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_FREE,  4'd0,  12'd2048, 1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_ALLOC, 4'd1,  12'd0,    1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_ALLOC, 4'd0,  12'd0,    1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_ALLOC, 4'd2,  12'd0,    1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_ALLOC, 4'd0,  12'd0,    1'b0, ST_OK,        12'd0,    13'd0},
        '{CMD_FREE,  4'd0,  12'd2048, 1'b0, ST_OK,        12'd0,    13'd0}
    };

    // Main sequence.
    initial begin
        alloc_result_t fixed_res;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);

        // Directed table straight after reset.
        foreach (directed_rows[i]) begin
            fixed_res = '{directed_rows[i].status, directed_rows[i].index,
                          directed_rows[i].free_pages};
            send_request(directed_rows[i].cmd, directed_rows[i].order, directed_rows[i].page,
                         directed_rows[i].fixed, fixed_res);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        // Random phases over several pool settings and idling patterns.
        run_phase(36'd0, 36'd256, 0, 0, 200, 1'b1, 1'b0);
        run_phase(36'hF_FFFF_FFFF, 36'hF_FFFF_FFFF, 78, 0, 200, 1'b0, 1'b0);
        run_phase(36'd5, 36'd100, 0, 78, 200, 1'b1, 1'b1);
        run_phase(36'd0, 36'd0, 23, 23, 100, 1'b0, 1'b0);
        run_phase(36'($urandom_range(1023)), 36'd2, 0, 0, 80, 1'b1, 1'b0);
        run_phase(36'd64, 36'd64, 23, 23, 200, 1'b1, 1'b0);
        run_phase(36'd0, 36'd4096, 0, 0, 200, 1'b0, 1'b0);

        wait_idle();
        if (error_count == 0)
            $display("buddy_page_allocator_tb: done, clean");
        else
            $display("buddy_page_allocator_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_datapath.sv
rtl/bpa_ctrl.sv
rtl/buddy_page_allocator.sv
tb/buddy_page_allocator_tb.sv
